// ===== rtl/cfb_pkg.sv =====
// Shared constants and codes for the CRC32 frame builder.
package cfb_pkg;

	// Reflected CRC32 polynomial, preset and final inversion mask
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	// Register reset values
	localparam logic [15:0] MAX_PAYLOAD_RST = 16'd4112;
	localparam logic [31:0] MAGIC_WORD_RST  = 32'h4655_5331;

	// Configuration register indexes
	localparam logic REG_MAX_PAYLOAD = 1'b0;
	localparam logic REG_MAGIC_WORD  = 1'b1;

	// Request codes
	localparam logic REQ_START   = 1'b0;
	localparam logic REQ_PAYLOAD = 1'b1;

	// Header length and the index of its last byte
	localparam logic [3:0] HDR_BYTES    = 4'd8;
	localparam logic [3:0] HDR_LAST_IDX = 4'd7;
	localparam logic [3:0] CRC_BYTES    = 4'd4;

endpackage

// ===== rtl/cfb_crc_fold.sv =====
// Folds one byte into a reflected CRC32 register, one bit per step.
module cfb_crc_fold (
	input  logic [31:0] crc_in,
	input  logic [7:0]  data,
	output logic [31:0] crc_out
);

	// Xor the byte in, then shift out eight bits
	always_comb begin
		logic [31:0] c;
		c = crc_in ^ {24'd0, data};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? (cfb_pkg::CRC_POLY ^ {1'b0, c[31:1]}) : {1'b0, c[31:1]};
		end
		crc_out = c;
	end

endmodule

// ===== rtl/crc32_frame_builder_core.sv =====
// Top level of the CRC32 frame builder: input register, byte sequencer, output register.
// An accepted item is held in the input register; its bytes are registered in the output byte register.
// Throughput: one wire byte per cycle while out_ready holds, set by the single output byte register; a payload
// item gives 1 byte (5 when it closes the frame), a start item 8 bytes (12 on an empty frame).
// A dropped surplus payload item shows nothing on the output.
// Reset (arst_n low): registers return to defaults, sequence 0, CRC all ones, no frame open.
module crc32_frame_builder_core (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [15:0] req_len,
	input  logic [7:0]  data_byte,
	// output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        frame_end,
	output logic        run_last
);

	// Configuration registers
	logic [15:0] max_payload_q;
	logic [31:0] magic_word_q;

	// Frame state
	logic [15:0] seq_q;
	logic [31:0] crc_q;
	logic [15:0] left_q;

	// Input register
	logic        valid_s1;
	logic        req_s1;
	logic [15:0] len_s1;
	logic [7:0]  data_s1;

	// Sequencer
	logic [3:0]  idx_q;
	logic        tail_q;

	logic        is_start;
	logic        drop;
	logic        emit;
	logic        tail_now;
	logic [3:0]  data_last;
	logic [3:0]  last_idx;
	logic        in_data;
	logic        is_last;
	logic        finish;
	logic [1:0]  crc_k;
	logic [31:0] crc_fin;
	logic [7:0]  hdr_byte;
	logic [7:0]  byte_sel;
	logic [31:0] crc_base;
	logic [31:0] crc_next;
	logic        in_fire;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= cfb_pkg::MAX_PAYLOAD_RST;
			magic_word_q  <= cfb_pkg::MAGIC_WORD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cfb_pkg::REG_MAX_PAYLOAD: max_payload_q <= cfg_data[15:0];
				cfb_pkg::REG_MAGIC_WORD:  magic_word_q  <= cfg_data;
				default:                  magic_word_q  <= magic_word_q;
			endcase
		end
	end

	// Decode the held item
	assign is_start  = (req_s1 == cfb_pkg::REQ_START);
	assign drop      = valid_s1 && !is_start && (idx_q == 4'd0) && (left_q == 16'd0);
	assign emit      = valid_s1 && !drop && (!out_valid || out_ready);
	assign tail_now  = (idx_q == 4'd0) ? (is_start ? (len_s1 == 16'd0) : (left_q == 16'd1))
	                                   : tail_q;
	assign data_last = is_start ? cfb_pkg::HDR_LAST_IDX : 4'd0;
	assign last_idx  = tail_now ? (data_last + cfb_pkg::CRC_BYTES) : data_last;
	assign in_data   = is_start ? (idx_q < cfb_pkg::HDR_BYTES) : (idx_q == 4'd0);
	assign is_last   = (idx_q == last_idx);
	assign finish    = drop || (emit && is_last);
	assign in_ready  = !valid_s1 || finish;
	assign in_fire   = in_valid && in_ready;

	// Pick the CRC byte: start items place it after 8 header bytes, payload after 1
	assign crc_k   = is_start ? idx_q[1:0] : (idx_q[1:0] - 2'd1);
	assign crc_fin = crc_q ^ cfb_pkg::CRC_INIT;

	// Select the header byte, little-endian fields
	always_comb begin
		unique case (idx_q[2:0])
			3'd0:    hdr_byte = magic_word_q[7:0];
			3'd1:    hdr_byte = magic_word_q[15:8];
			3'd2:    hdr_byte = magic_word_q[23:16];
			3'd3:    hdr_byte = magic_word_q[31:24];
			3'd4:    hdr_byte = seq_q[7:0];
			3'd5:    hdr_byte = seq_q[15:8];
			3'd6:    hdr_byte = len_s1[7:0];
			default: hdr_byte = len_s1[15:8];
		endcase
	end

	// Select the wire byte
	always_comb begin
		if (in_data) begin
			byte_sel = is_start ? hdr_byte : data_s1;
		end else begin
			unique case (crc_k)
				2'd0:    byte_sel = crc_fin[7:0];
				2'd1:    byte_sel = crc_fin[15:8];
				2'd2:    byte_sel = crc_fin[23:16];
				default: byte_sel = crc_fin[31:24];
			endcase
		end
	end

	// Restart the CRC on the first header byte
	assign crc_base = (is_start && (idx_q == 4'd0)) ? cfb_pkg::CRC_INIT : crc_q;

	cfb_crc_fold u_fold (
		.crc_in  (crc_base),
		.data    (byte_sel),
		.crc_out (crc_next)
	);

	// Load the input register, clamping the length to the maximum payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_s1  <= req_type;
			len_s1  <= (req_len > max_payload_q) ? max_payload_q : req_len;
			data_s1 <= data_byte;
		end
	end

	// Advance the byte index and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= 4'd0;
			tail_q <= 1'b0;
			seq_q  <= 16'd0;
			crc_q  <= cfb_pkg::CRC_INIT;
			left_q <= 16'd0;
		end else if (emit) begin
			idx_q  <= is_last ? 4'd0 : (idx_q + 4'd1);
			tail_q <= tail_now;
			if (in_data) begin
				crc_q <= crc_next;
			end
			if (idx_q == 4'd0) begin
				if (is_start) begin
					seq_q  <= seq_q + 16'd1;
					left_q <= len_s1;
				end else begin
					left_q <= left_q - 16'd1;
				end
			end
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte  <= byte_sel;
			frame_end <= !in_data && (crc_k == 2'd3);
			run_last  <= is_last;
		end
	end

	// The closing CRC byte always ends the item's run
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> run_last)
		else $error("frame_end without run_last");

	// The byte index never runs past the longest item
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= (cfb_pkg::HDR_LAST_IDX + cfb_pkg::CRC_BYTES))
		else $error("byte index out of range");

	// CRC bytes are only sent when the frame closes on this item
	a_crc_tail: assert property (@(posedge clk) disable iff (!arst_n)
		emit && !in_data |-> tail_now)
		else $error("CRC byte sent on an open frame");

	// A start item bumps the sequence number once
	a_seq_step: assert property (@(posedge clk) disable iff (!arst_n)
		emit && is_start && (idx_q == 4'd0) |=> seq_q == $past(seq_q) + 16'd1)
		else $error("sequence number not advanced");

endmodule

// ===== sim/cfb_check_pkg.sv =====
// Wire byte prediction and checking for the CRC32 frame builder testbench.
package cfb_check_pkg;

	typedef struct packed {
		logic [7:0] data;
		logic       frame_end;
		logic       run_last;
	} wire_byte_t;

	class frame_wire_check;
		logic [15:0] max_payload;
		logic [31:0] magic_word;
		logic [15:0] seq_count;
		logic [31:0] crc_accum;
		logic [15:0] bytes_left;
		wire_byte_t  wire_due[$];
		int          errors;

		function new();
			max_payload = cfb_pkg::MAX_PAYLOAD_RST;
			magic_word  = cfb_pkg::MAGIC_WORD_RST;
			seq_count   = '0;
			crc_accum   = cfb_pkg::CRC_INIT;
			bytes_left  = '0;
			errors      = 0;
		endfunction

		function void set_reg(logic index, logic [31:0] value);
			if (index == cfb_pkg::REG_MAX_PAYLOAD) begin
				max_payload = value[15:0];
			end else begin
				magic_word = value;
			end
		endfunction

		// Queue one wire byte, folding it into the running CRC when asked
		function void emit(logic [7:0] value, bit fold);
			wire_byte_t w;
			int k;
			w.data      = value;
			w.frame_end = 1'b0;
			w.run_last  = 1'b0;
			wire_due.push_back(w);
			if (fold) begin
				crc_accum ^= {24'd0, value};
				for (k = 0; k < 8; k++) begin
					crc_accum = crc_accum[0] ? ((crc_accum >> 1) ^ cfb_pkg::CRC_POLY)
					                         : (crc_accum >> 1);
				end
			end
		endfunction

		// Append the inverted CRC, low byte first, and mark the frame end
		function void emit_crc();
			logic [31:0] crc;
			wire_byte_t w;
			int i;
			crc = crc_accum ^ cfb_pkg::CRC_INIT;
			for (i = 0; i < 4; i++) begin
				emit(crc[8*i +: 8], 1'b0);
			end
			w = wire_due.pop_back();
			w.frame_end = 1'b1;
			wire_due.push_back(w);
		endfunction

		// Predict the wire bytes caused by one accepted item; return their count
		function int note_request(logic req, logic [15:0] len, logic [7:0] db);
			int start_n;
			int i;
			logic [15:0] clamped;
			wire_byte_t w;
			start_n = wire_due.size();
			if (req == cfb_pkg::REQ_START) begin
				clamped = (len > max_payload) ? max_payload : len;
				seq_count++;
				crc_accum = cfb_pkg::CRC_INIT;
				for (i = 0; i < 4; i++) begin
					emit(magic_word[8*i +: 8], 1'b1);
				end
				emit(seq_count[7:0], 1'b1);
				emit(seq_count[15:8], 1'b1);
				emit(clamped[7:0], 1'b1);
				emit(clamped[15:8], 1'b1);
				bytes_left = clamped;
				if (bytes_left == 0) begin
					emit_crc();
				end
			end else begin
				// surplus byte with no frame open: dropped
				if (bytes_left == 0) begin
					return 0;
				end
				emit(db, 1'b1);
				bytes_left--;
				if (bytes_left == 0) begin
					emit_crc();
				end
			end
			w = wire_due.pop_back();
			w.run_last = 1'b1;
			wire_due.push_back(w);
			return wire_due.size() - start_n;
		endfunction

		// Compare one accepted wire byte against the oldest prediction
		function void check_wire_byte(logic [7:0] data, logic fend, logic rlast);
			wire_byte_t w;
			if (wire_due.size() == 0) begin
				$error("out_byte: expected nothing, got %02h", data);
				errors++;
				return;
			end
			w = wire_due.pop_front();
			if (data !== w.data) begin
				$error("out_byte: expected %02h, got %02h", w.data, data);
				errors++;
			end
			if (fend !== w.frame_end) begin
				$error("frame_end: expected %0b, got %0b", w.frame_end, fend);
				errors++;
			end
			if (rlast !== w.run_last) begin
				$error("run_last: expected %0b, got %0b", w.run_last, rlast);
				errors++;
			end
		endfunction

		function int pending();
			return wire_due.size();
		endfunction
	endclass

endpackage

// ===== sim/tb.sv =====
// Testbench top for the CRC32 frame builder: stimulus, handshakes and final verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 3_000_000;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic        cfg_index = cfb_pkg::REG_MAX_PAYLOAD;
	logic [31:0] cfg_data  = '0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic        req_type  = cfb_pkg::REQ_START;
	logic [15:0] req_len   = '0;
	logic [7:0]  data_byte = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        frame_end;
	logic        run_last;

	cfb_check_pkg::frame_wire_check chk = new();
	bit in_gaps;
	bit out_stalls;
	int items_done;
	int cycles;

	crc32_frame_builder_core dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one item, with an occasional idle burst first, and hold until taken
	task automatic push_item(input logic rt, input logic [15:0] len, input logic [7:0] db);
		if (in_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		req_type  <= rt;
		req_len   <= len;
		data_byte <= db;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (chk.note_request(rt, len, db) != 0) items_done++;
	endtask

	// Wait for every predicted byte, then let a dropped item clear the pipe
	task automatic drain();
		in_valid <= 1'b0;
		while (chk.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write both registers while the block is idle
	task automatic set_regs(input logic [15:0] max_len, input logic [31:0] magic);
		logic [31:0] max_word;
		drain();
		max_word  = {16'($urandom), max_len};
		cfg_we    <= 1'b1;
		cfg_index <= cfb_pkg::REG_MAX_PAYLOAD;
		cfg_data  <= max_word;
		@(posedge clk);
		chk.set_reg(cfb_pkg::REG_MAX_PAYLOAD, max_word);
		cfg_index <= cfb_pkg::REG_MAGIC_WORD;
		cfg_data  <= magic;
		@(posedge clk);
		chk.set_reg(cfb_pkg::REG_MAGIC_WORD, magic);
		cfg_we <= 1'b0;
	endtask

	// Mostly whole frames with random content; some cut short, padded or stray bytes
	task automatic random_frame();
		int unsigned roll;
		int unsigned want;
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			push_item(cfb_pkg::REQ_PAYLOAD, 16'($urandom), 8'($urandom));
			return;
		end
		push_item(cfb_pkg::REQ_START,
			(roll < 20) ? 16'($urandom) : 16'($urandom_range(0, 12)), 8'($urandom));
		want = (chk.bytes_left > 24) ? 24 : chk.bytes_left;
		roll = $urandom_range(0, 9);
		if (roll == 0 && want > 0) begin
			want = $urandom_range(0, want - 1);
		end else if (roll == 1) begin
			want = want + 2;
		end
		repeat (want) push_item(cfb_pkg::REQ_PAYLOAD, 16'($urandom), 8'($urandom));
	endtask

	task automatic run_phase(input logic [15:0] max_len, input logic [31:0] magic,
		input int target);
		set_regs(max_len, magic);
		items_done = 0;
		while (items_done < target) random_frame();
	endtask

	// Receiver: alternate ready bursts with optional stall bursts
	initial begin
		@(posedge clk);
		forever begin
			if (out_stalls && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	// Check every accepted wire byte
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) chk.check_wire_byte(out_byte, frame_end, run_last);
	end

	// Bound the run
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("crc32_frame_builder_core test failed");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		in_gaps    = 1'b1;
		out_stalls = 1'b1;

		// Directed: reset registers, dropped byte, empty frame, clamping, abandon
		push_item(cfb_pkg::REQ_PAYLOAD, 16'hFFFF, 8'hFF);
		push_item(cfb_pkg::REQ_START, 16'd0, 8'h00);
		push_item(cfb_pkg::REQ_START, 16'd3, 8'hFF);
		push_item(cfb_pkg::REQ_PAYLOAD, 16'h0000, 8'h00);
		push_item(cfb_pkg::REQ_PAYLOAD, 16'hFFFF, 8'hFF);
		push_item(cfb_pkg::REQ_PAYLOAD, 16'h1234, 8'hA5);
		push_item(cfb_pkg::REQ_PAYLOAD, 16'h0000, 8'h5A);
		push_item(cfb_pkg::REQ_START, 16'hFFFF, 8'h00);
		push_item(cfb_pkg::REQ_PAYLOAD, 16'h0000, 8'h01);
		push_item(cfb_pkg::REQ_PAYLOAD, 16'h0000, 8'hFE);
		push_item(cfb_pkg::REQ_START, 16'd4113, 8'h00);
		push_item(cfb_pkg::REQ_PAYLOAD, 16'h0000, 8'h7F);
		push_item(cfb_pkg::REQ_START, 16'd1, 8'h00);
		push_item(cfb_pkg::REQ_PAYLOAD, 16'h0000, 8'h80);

		// Directed: smallest limit and magic, then largest
		set_regs(16'd0, 32'h0000_0000);
		push_item(cfb_pkg::REQ_START, 16'hFFFF, 8'h00);
		push_item(cfb_pkg::REQ_PAYLOAD, 16'h0000, 8'h33);
		set_regs(16'hFFFF, 32'hFFFF_FFFF);
		push_item(cfb_pkg::REQ_START, 16'hFFFF, 8'h00);
		push_item(cfb_pkg::REQ_PAYLOAD, 16'h0000, 8'hC3);
		push_item(cfb_pkg::REQ_PAYLOAD, 16'h0000, 8'h3C);
		push_item(cfb_pkg::REQ_START, 16'd2, 8'h00);
		push_item(cfb_pkg::REQ_PAYLOAD, 16'h0000, 8'h0F);
		push_item(cfb_pkg::REQ_PAYLOAD, 16'h0000, 8'hF0);

		// Empty frames back to back at full rate
		in_gaps    = 1'b0;
		out_stalls = 1'b0;
		repeat (4) push_item(cfb_pkg::REQ_START, 16'd0, 8'($urandom));
		in_gaps    = 1'b1;
		out_stalls = 1'b1;

		// Random phases over several register settings
		run_phase(16'd3, $urandom, 36);
		run_phase(16'($urandom_range(4, 40)), $urandom, 36);
		run_phase(cfb_pkg::MAX_PAYLOAD_RST, cfb_pkg::MAGIC_WORD_RST, 36);
		in_gaps    = 1'b0;
		out_stalls = 1'b0;
		run_phase(16'd1, $urandom, 36);

		drain();
		if (chk.errors == 0 && chk.pending() == 0) begin
			$display("crc32_frame_builder_core test passed");
		end else begin
			$display("crc32_frame_builder_core test failed");
		end
		$finish;
	end

endmodule

// ===== crc32_frame_builder_core.f =====
rtl/cfb_pkg.sv
rtl/cfb_crc_fold.sv
rtl/crc32_frame_builder_core.sv
sim/cfb_check_pkg.sv
sim/tb.sv
